>>> hdl/bpb_pkg.sv
`timescale 1ns / 1ps

package bpb_pkg;

    localparam int VALUE_W      = 32;
    localparam int DIGITS_W     = 4;
    localparam int BCD_W        = 40;
    localparam int BYTES_W      = 3;
    localparam int SIG_W        = 4;
    localparam int DIGIT_W      = 4;
    // Decimal digits a VALUE_W-bit number can have
    localparam int BCD_DIGITS   = 10;
    localparam int MAX_DIGITS_DEF = 10;
    localparam int BIT_CNT_W    = $clog2(VALUE_W);

    // Stream widths, rounded up to whole bytes
    localparam int S_TDATA_W    = ((VALUE_W + DIGITS_W + 7) / 8) * 8;
    localparam int M_TDATA_W    = ((BCD_W + BYTES_W + SIG_W + 7) / 8) * 8;

    // Controls driven from the sequencer into the cell row
    typedef struct packed {
        logic load;
        logic shift;
    } bpb_ctl_t;

endpackage

>>> hdl/bpb_cell.sv
`timescale 1ns / 1ps

// One decimal digit of the shift-add-3 row.
module bpb_cell
(
    input  logic                         clk,
    input  logic                         clear,
    input  logic                         shift,
    input  logic                         din,
    output logic                         dout,
    output logic [bpb_pkg::DIGIT_W-1:0]  digit
);

    logic [bpb_pkg::DIGIT_W-1:0] digit_reg;
    logic [bpb_pkg::DIGIT_W-1:0] digit_next;
    logic [bpb_pkg::DIGIT_W-1:0] adj;

    // Add 3 when the digit would reach ten or more after the doubling
    assign adj  = (digit_reg >= bpb_pkg::DIGIT_W'(5)) ?
                  digit_reg + bpb_pkg::DIGIT_W'(3) : digit_reg;
    assign dout = adj[bpb_pkg::DIGIT_W-1];

    always_comb
    begin
        if (clear)
        begin
            digit_next = '0;
        end
        else if (shift)
        begin
            digit_next = {adj[bpb_pkg::DIGIT_W-2:0], din};
        end
        else
        begin
            digit_next = digit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign digit = digit_reg;

endmodule

>>> hdl/bpb_chain.sv
`timescale 1ns / 1ps

// Binary shift register feeding a row of BCD digit cells.
module bpb_chain
#(
    parameter int NUM_CELLS = bpb_pkg::BCD_DIGITS
)
(
    input  logic                                     clk,
    input  bpb_pkg::bpb_ctl_t                        ctl,
    input  logic [bpb_pkg::VALUE_W-1:0]              value,
    output logic [NUM_CELLS*bpb_pkg::DIGIT_W-1:0]    digits_vec,
    output logic                                     spill
);

    logic [bpb_pkg::VALUE_W-1:0] value_reg;
    logic                        spill_reg;
    logic [NUM_CELLS:0]          carry;

    // Binary bits enter the lowest cell, MSB first
    assign carry[0] = value_reg[bpb_pkg::VALUE_W-1];

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        bpb_cell u_cell
        (
            .clk   (clk),
            .clear (ctl.load),
            .shift (ctl.shift),
            .din   (carry[i]),
            .dout  (carry[i+1]),
            .digit (digits_vec[i*bpb_pkg::DIGIT_W +: bpb_pkg::DIGIT_W])
        );
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            value_reg <= value;
            spill_reg <= 1'b0;
        end
        else if (ctl.shift)
        begin
            value_reg <= {value_reg[bpb_pkg::VALUE_W-2:0], 1'b0};
            // Any bit leaving the top cell means the value exceeds the row
            spill_reg <= spill_reg | carry[NUM_CELLS];
        end
    end

    assign spill = spill_reg;

endmodule

>>> hdl/binary_to_packed_bcd.sv
`timescale 1ns / 1ps

// Binary to packed BCD converter. Each input transfer carries a 32-bit
// unsigned value and a digit count; one output transfer returns the low
// 'digits' decimal digits as packed BCD (units digit in the low nibble,
// unused nibbles zero), the byte count (digits+1)/2 (one for a zero count),
// the number of significant digits capped at the count, and an overflow flag
// on m_axis_tuser that is set when nonzero higher digits were dropped. A
// count above MAX_DIGITS is treated as MAX_DIGITS. Conversion runs through a
// row of shift-add-3 digit cells, one input bit per clock: an item is loaded,
// shifted through all of its value bits, then finished into the output
// register, and one item is in work at a time. The result sits
// in an output register, so a new input is taken while a result still waits,
// but its finish stalls until that result is taken.
module binary_to_packed_bcd
#(
    parameter int MAX_DIGITS = bpb_pkg::MAX_DIGITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [31:0] value, [35:32] digits, [39:36] zero
    input  logic [bpb_pkg::S_TDATA_W-1:0]     s_axis_tdata,

    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [39:0] bcd_packed, [42:40] byte_count, [46:43] sig_digits, [47] zero
    output logic [bpb_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // [0] overflow
    output logic                              m_axis_tuser
);

    // Digits above the row's top are never shown, so the row stops there
    localparam int NUM_CELLS = (MAX_DIGITS < bpb_pkg::BCD_DIGITS) ?
                               MAX_DIGITS : bpb_pkg::BCD_DIGITS;
    localparam int PAD_W     = bpb_pkg::M_TDATA_W - bpb_pkg::BCD_W
                               - bpb_pkg::BYTES_W - bpb_pkg::SIG_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_FINISH
    } state_t;

    state_t                             state_reg;
    logic [bpb_pkg::BIT_CNT_W-1:0]      bit_cnt_reg;
    logic [bpb_pkg::DIGITS_W-1:0]       count_reg;
    logic                               m_valid_reg;
    logic [bpb_pkg::BCD_W-1:0]          bcd_reg;
    logic [bpb_pkg::BYTES_W-1:0]        bytes_reg;
    logic [bpb_pkg::SIG_W-1:0]          sig_reg;
    logic                               ovf_reg;

    logic [bpb_pkg::VALUE_W-1:0]        in_value;
    logic [bpb_pkg::DIGITS_W-1:0]       in_digits;
    logic [bpb_pkg::DIGITS_W-1:0]       in_count;
    logic                               in_xfer;
    logic                               out_free;
    logic                               fin_xfer;

    bpb_pkg::bpb_ctl_t                  ctl;
    logic [NUM_CELLS*bpb_pkg::DIGIT_W-1:0] digits_vec;
    logic                               spill;

    logic [bpb_pkg::BCD_W-1:0]          bcd_next;
    logic [bpb_pkg::BYTES_W-1:0]        bytes_next;
    logic [bpb_pkg::SIG_W-1:0]          sig_next;
    logic [bpb_pkg::SIG_W-1:0]          ndig;
    logic                               ovf_next;

    assign in_value  = s_axis_tdata[bpb_pkg::VALUE_W-1:0];
    assign in_digits = s_axis_tdata[bpb_pkg::VALUE_W +: bpb_pkg::DIGITS_W];

    // Saturate the digit count at MAX_DIGITS
    assign in_count  = (int'(in_digits) > MAX_DIGITS) ?
                       bpb_pkg::DIGITS_W'(MAX_DIGITS) : in_digits;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    // A finished conversion moves into the output register this cycle
    assign fin_xfer      = (state_reg == ST_FINISH) && out_free;

    assign ctl.load  = in_xfer;
    assign ctl.shift = (state_reg == ST_SHIFT);

    bpb_chain
    #(
        .NUM_CELLS (NUM_CELLS)
    )
    u_chain
    (
        .clk        (clk),
        .ctl        (ctl),
        .value      (in_value),
        .digits_vec (digits_vec),
        .spill      (spill)
    );

    // Finish: mask digits at or above the count, find overflow and length
    always_comb
    begin
        bcd_next = '0;
        ovf_next = spill;
        ndig     = '0;
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            if (bpb_pkg::SIG_W'(i) < count_reg)
            begin
                bcd_next[i*bpb_pkg::DIGIT_W +: bpb_pkg::DIGIT_W] =
                    digits_vec[i*bpb_pkg::DIGIT_W +: bpb_pkg::DIGIT_W];
            end
            else if (digits_vec[i*bpb_pkg::DIGIT_W +: bpb_pkg::DIGIT_W] != '0)
            begin
                ovf_next = 1'b1;
            end
            if (digits_vec[i*bpb_pkg::DIGIT_W +: bpb_pkg::DIGIT_W] != '0)
            begin
                ndig = bpb_pkg::SIG_W'(i + 1);
            end
        end
        // A spill past the top cell means every requested digit is significant
        if (spill || (ndig > count_reg))
        begin
            sig_next = count_reg;
        end
        else
        begin
            sig_next = ndig;
        end
        if (count_reg == '0)
        begin
            bytes_next = bpb_pkg::BYTES_W'(1);
        end
        else
        begin
            bytes_next = bpb_pkg::BYTES_W'(({1'b0, count_reg} + 5'd1) >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            bcd_reg     <= '0;
            bytes_reg   <= '0;
            sig_reg     <= '0;
            ovf_reg     <= 1'b0;
        end
        else
        begin
            // Show a finished result, or drop the shown one once it is taken
            if (fin_xfer)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        count_reg   <= in_count;
                        bit_cnt_reg <= '0;
                        state_reg   <= ST_SHIFT;
                    end
                end
                ST_SHIFT:
                begin
                    bit_cnt_reg <= bit_cnt_reg + bpb_pkg::BIT_CNT_W'(1);
                    if (bit_cnt_reg == bpb_pkg::BIT_CNT_W'(bpb_pkg::VALUE_W - 1))
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    // Hold here until the output register is free
                    if (fin_xfer)
                    begin
                        bcd_reg     <= bcd_next;
                        bytes_reg   <= bytes_next;
                        sig_reg     <= sig_next;
                        ovf_reg     <= ovf_next;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, sig_reg, bytes_reg, bcd_reg};
    assign m_axis_tuser  = ovf_reg;

endmodule

>>> hdl/bpb_checker.sv
`timescale 1ns / 1ps

module bpb_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [bpb_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    input  logic                              m_axis_tuser
);

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("output payload changed while stalled");

    // One item in work at a time: input closes after a transfer
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while a conversion is running");

    // No significant digits means an all-zero BCD field
    a_zero_sig: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata[46:43] == 4'd0)) |->
            (m_axis_tdata[39:0] == 40'd0))
        else $error("nonzero BCD with zero significant digits");

endmodule

bind binary_to_packed_bcd bpb_checker u_bpb_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
